// ===== rtl/dqc_pkg.sv =====
// Shared definitions for the deque-with-cursor block: operation and status codes,
// result word layout and width helpers.
// No dependencies; imported by deque_with_cursor, dqc_checker and the testbench.
package dqc_pkg;

    localparam int DQC_DEPTH = 64;
    localparam int ITEM_W    = 32;

    // operation selector carried on s_tuser
    typedef enum logic [2:0] {
        MODE_PUSH_LEFT   = 3'd0,
        MODE_PUSH_RIGHT  = 3'd1,
        MODE_POP_LEFT    = 3'd2,
        MODE_POP_RIGHT   = 3'd3,
        MODE_CURSOR_LEFT = 3'd4,
        MODE_CURSOR_RIGHT= 3'd5,
        MODE_SET_CURSOR  = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_END   = 2'd3
    } status_t;

    // result word layout, lowest bit first
    localparam int RES_STATUS_LSB = 0;
    localparam int RES_POP_LSB    = 2;
    localparam int RES_LEFT_LSB   = 34;
    localparam int RES_RIGHT_LSB  = 66;
    localparam int RES_CURSOR_LSB = 98;
    localparam int RES_EMPTY_BIT  = 130;
    localparam int RES_COUNT_LSB  = 131;

    function automatic int idx_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic int cnt_width(input int depth);
        return $clog2(depth + 1);
    endfunction

    function automatic int out_width(input int depth);
        return ((RES_COUNT_LSB + cnt_width(depth) + 7) / 8) * 8;
    endfunction

endpackage

// ===== rtl/deque_with_cursor.sv =====
// Deque with cursor: bounded double-ended queue of signed 32-bit items in a ring buffer.
// A word is accepted on every cycle in which s_tvalid and s_tready are both high, and
// the block sustains one word per cycle while s_tready is high. The pointer update and
// the item store read happen in the accepting cycle; in the next, the read stage merges
// the read data and the result word is written to the output buffer, raising m_tvalid.
// The item store is kept as four copies of a one-write, one-read RAM so that the pop,
// left, right and cursor items can all be read in the same cycle; a two-word output
// buffer lets a new word in while a finished result still waits. s_tready drops only
// when that buffer would fill.
// Depends on dqc_pkg and dqc_ram.
module deque_with_cursor #(
    parameter int DEPTH = dqc_pkg::DQC_DEPTH,
    localparam int OUT_W = dqc_pkg::out_width(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input channel
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [dqc_pkg::ITEM_W-1:0] s_tdata,  // [31:0] item_value
    input  logic [2:0]                 s_tuser,  // [2:0] mode
    // result channel
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [1:0] status, [33:2] popped_value, [65:34] left_item, [97:66] right_item,
    // [129:98] cursor_item, [130] is_empty, then item_count, zero padded to bytes
    output logic [OUT_W-1:0]           m_tdata
);

    import dqc_pkg::*;

    localparam int IDX_W = idx_width(DEPTH);
    localparam int CNT_W = cnt_width(DEPTH);
    localparam logic [IDX_W:0]   DEPTH_E  = (IDX_W+1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

    // ring index a + b, both below DEPTH
    function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        logic [IDX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_E) begin
            sum = sum - DEPTH_E;
        end
        return sum[IDX_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Deque state
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] left_reg, left_next;
    logic [CNT_W-1:0] occ_reg,  occ_next;
    logic [IDX_W-1:0] cur_reg,  cur_next;

    logic             accept;
    mode_t            mode;
    status_t          status;
    logic             is_full, is_none;
    logic [CNT_W-1:0] occ_m1, occ_m2, occ_next_m1;
    logic [CNT_W-1:0] cur_ext;
    logic [IDX_W-1:0] tail_idx, last_idx, cur_idx;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             pop_ok;
    logic [IDX_W-1:0] pop_addr;
    logic [IDX_W-1:0] rd_left, rd_right, rd_cur;

    assign accept  = s_tvalid && s_tready;
    assign mode    = mode_t'(s_tuser);
    assign is_full = (occ_reg == DEPTH_C);
    assign is_none = (occ_reg == '0);
    assign occ_m1  = occ_reg - CNT_W'(1);
    assign occ_m2  = occ_reg - CNT_W'(2);
    assign cur_ext = CNT_W'(cur_reg);

    // slot just past the right end, slot of the right end, slot under the cursor
    assign tail_idx = idx_add(left_reg, occ_reg[IDX_W-1:0]);
    assign last_idx = idx_add(left_reg, occ_m1[IDX_W-1:0]);
    assign cur_idx  = idx_add(left_reg, cur_reg);

    always_comb begin
        left_next = left_reg;
        occ_next  = occ_reg;
        cur_next  = cur_reg;
        status    = ST_OK;
        wr_en     = 1'b0;
        wr_addr   = cur_idx;
        pop_ok    = 1'b0;
        pop_addr  = left_reg;
        if (accept) begin
            unique case (mode)
                MODE_PUSH_LEFT: begin
                    if (is_full) begin
                        status = ST_FULL;
                    end else begin
                        left_next = (left_reg == '0) ? LAST_IDX : left_reg - IDX_W'(1);
                        wr_en     = 1'b1;
                        wr_addr   = left_next;
                        // existing items shift one place right of the new left end
                        cur_next  = is_none ? '0 : cur_reg + IDX_W'(1);
                        occ_next  = occ_reg + CNT_W'(1);
                    end
                end
                MODE_PUSH_RIGHT: begin
                    if (is_full) begin
                        status = ST_FULL;
                    end else begin
                        wr_en    = 1'b1;
                        wr_addr  = tail_idx;
                        cur_next = is_none ? '0 : cur_reg;
                        occ_next = occ_reg + CNT_W'(1);
                    end
                end
                MODE_POP_LEFT: begin
                    if (is_none) begin
                        status = ST_EMPTY;
                    end else begin
                        pop_ok    = 1'b1;
                        pop_addr  = left_reg;
                        left_next = (left_reg == LAST_IDX) ? '0 : left_reg + IDX_W'(1);
                        occ_next  = occ_m1;
                        // cursor keeps its item, or lands on the new left end
                        cur_next  = (cur_reg != '0) ? cur_reg - IDX_W'(1) : '0;
                    end
                end
                MODE_POP_RIGHT: begin
                    if (is_none) begin
                        status = ST_EMPTY;
                    end else begin
                        pop_ok   = 1'b1;
                        pop_addr = last_idx;
                        occ_next = occ_m1;
                        if (cur_ext >= occ_m1) begin
                            cur_next = (occ_m1 == '0) ? '0 : occ_m2[IDX_W-1:0];
                        end
                    end
                end
                MODE_CURSOR_LEFT: begin
                    if (is_none) begin
                        status = ST_EMPTY;
                    end else if (cur_reg == '0) begin
                        status = ST_END;
                    end else begin
                        cur_next = cur_reg - IDX_W'(1);
                    end
                end
                MODE_CURSOR_RIGHT: begin
                    if (is_none) begin
                        status = ST_EMPTY;
                    end else if (cur_ext + CNT_W'(1) >= occ_reg) begin
                        status = ST_END;
                    end else begin
                        cur_next = cur_reg + IDX_W'(1);
                    end
                end
                MODE_SET_CURSOR: begin
                    if (is_none) begin
                        status = ST_EMPTY;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = cur_idx;
                    end
                end
                default: begin
                    // unused code: no operation
                end
            endcase
        end
    end

    // read addresses for the state after this word
    assign occ_next_m1 = occ_next - CNT_W'(1);
    assign rd_left     = left_next;
    assign rd_right    = idx_add(left_next, occ_next_m1[IDX_W-1:0]);
    assign rd_cur      = idx_add(left_next, cur_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
            occ_reg  <= '0;
            cur_reg  <= '0;
        end else begin
            left_reg <= left_next;
            occ_reg  <= occ_next;
            cur_reg  <= cur_next;
        end
    end

    // ------------------------------------------------------------------
    // Item store: four copies written alike, each read at one address
    // ------------------------------------------------------------------
    logic [ITEM_W-1:0] q_pop, q_left, q_right, q_cur;

    dqc_ram #(.WIDTH(ITEM_W), .DEPTH(DEPTH)) u_ram_pop (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(s_tdata),
        .rd_addr(pop_addr), .rd_data(q_pop)
    );

    dqc_ram #(.WIDTH(ITEM_W), .DEPTH(DEPTH)) u_ram_left (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(s_tdata),
        .rd_addr(rd_left), .rd_data(q_left)
    );

    dqc_ram #(.WIDTH(ITEM_W), .DEPTH(DEPTH)) u_ram_right (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(s_tdata),
        .rd_addr(rd_right), .rd_data(q_right)
    );

    dqc_ram #(.WIDTH(ITEM_W), .DEPTH(DEPTH)) u_ram_cur (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(s_tdata),
        .rd_addr(rd_cur), .rd_data(q_cur)
    );

    // ------------------------------------------------------------------
    // Read stage: hold what the merge needs next cycle
    // ------------------------------------------------------------------
    logic              p1_valid_reg;
    status_t           p1_status_reg;
    logic              p1_pop_reg;
    logic              p1_empty_reg;
    logic [CNT_W-1:0]  p1_count_reg;
    logic              p1_hit_l_reg, p1_hit_r_reg, p1_hit_c_reg;
    logic [ITEM_W-1:0] p1_wdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        p1_status_reg <= status;
        p1_pop_reg    <= pop_ok;
        p1_empty_reg  <= (occ_next == '0);
        p1_count_reg  <= occ_next;
        // the RAM returns old data on a same-edge write, so flag those reads
        p1_hit_l_reg  <= wr_en && (wr_addr == rd_left);
        p1_hit_r_reg  <= wr_en && (wr_addr == rd_right);
        p1_hit_c_reg  <= wr_en && (wr_addr == rd_cur);
        p1_wdata_reg  <= s_tdata;
    end

    // merge bypassed write data and zero the items of an empty deque
    logic [ITEM_W-1:0] res_pop, res_left, res_right, res_cur;
    logic [OUT_W-1:0]  res_word;

    assign res_pop   = p1_pop_reg ? q_pop : '0;
    assign res_left  = p1_empty_reg ? '0 : (p1_hit_l_reg ? p1_wdata_reg : q_left);
    assign res_right = p1_empty_reg ? '0 : (p1_hit_r_reg ? p1_wdata_reg : q_right);
    assign res_cur   = p1_empty_reg ? '0 : (p1_hit_c_reg ? p1_wdata_reg : q_cur);
    assign res_word  = OUT_W'({p1_count_reg, p1_empty_reg, res_cur, res_right,
                               res_left, res_pop, p1_status_reg});

    // ------------------------------------------------------------------
    // Two-word output buffer
    // ------------------------------------------------------------------
    logic [OUT_W-1:0] fifo_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg, cnt_next, fill_est;
    logic             drain;

    assign drain    = m_tvalid && m_tready;
    // words held once the read stage lands, if this cycle's drain goes ahead
    assign fill_est = cnt_reg + {1'b0, p1_valid_reg} - {1'b0, drain};
    assign s_tready = (fill_est < 2'd2);
    assign cnt_next = cnt_reg + {1'b0, p1_valid_reg} - {1'b0, drain};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (p1_valid_reg) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (drain) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_valid_reg) begin
            fifo_reg[wr_ptr_reg] <= res_word;
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = fifo_reg[rd_ptr_reg];

endmodule

// ===== rtl/dqc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; instanced by deque_with_cursor for the item store copies.
module dqc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // read returns the contents before a same-edge write
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/dqc_checker.sv =====
// Port-level checks for deque_with_cursor, attached by the bind at the end of this file.
// Depends on dqc_pkg.
module dqc_checker #(
    parameter int DEPTH = dqc_pkg::DQC_DEPTH,
    localparam int OUT_W = dqc_pkg::out_width(DEPTH)
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [dqc_pkg::ITEM_W-1:0] s_tdata,
    input logic [2:0]                 s_tuser,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [OUT_W-1:0]           m_tdata
);

    import dqc_pkg::*;

    localparam int CNT_W = cnt_width(DEPTH);

    logic [1:0]        st;
    logic [ITEM_W-1:0] popped, left_v, right_v, cur_v;
    logic              empty;
    logic [CNT_W-1:0]  count;
    logic              in_seen;

    assign st      = m_tdata[RES_STATUS_LSB +: 2];
    assign popped  = m_tdata[RES_POP_LSB +: ITEM_W];
    assign left_v  = m_tdata[RES_LEFT_LSB +: ITEM_W];
    assign right_v = m_tdata[RES_RIGHT_LSB +: ITEM_W];
    assign cur_v   = m_tdata[RES_CURSOR_LSB +: ITEM_W];
    assign empty   = m_tdata[RES_EMPTY_BIT];
    assign count   = m_tdata[RES_COUNT_LSB +: CNT_W];
    assign in_seen = s_tvalid && s_tready && (s_tdata == s_tdata) && (s_tuser == s_tuser);

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // empty flag agrees with the count, and the count stays in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (empty == (count == '0)) && (count <= CNT_W'(DEPTH)))
        else $error("empty flag or item count inconsistent");

    // an empty deque shows no items
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && empty |-> (left_v == '0) && (right_v == '0) && (cur_v == '0))
        else $error("items shown for empty deque");

    // a failed operation pops nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st != ST_OK) |-> (popped == '0))
        else $error("popped value on failed operation");

    // no result appears unless an input word was accepted before it
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_seen ##1 !in_seen ##1 $rose(m_tvalid) |-> 1'b0)
        else $error("result word without input word");

endmodule

bind deque_with_cursor dqc_checker #(.DEPTH(DEPTH)) u_dqc_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for deque_with_cursor: random and directed operation words,
// a cycle-free predictor of the ring buffer and cursor, and a field-by-field result check.
// Depends on dqc_pkg and the deque_with_cursor RTL.
module testbench;
    import dqc_pkg::*;

    localparam int OUT_W        = out_width(DQC_DEPTH);
    localparam int CNT_W        = cnt_width(DQC_DEPTH);
    localparam int RANDOM_OPS   = 800;
    localparam int IDLE_LIMIT   = 2000;   // cycles with no word moving on either side
    localparam int HOLD_AT      = 300;    // input words taken before the long stall
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        mode_t       op;
        logic [31:0] value;
    } dq_op_t;

    typedef struct {
        status_t     status;
        logic [31:0] popped;
        logic [31:0] left_item;
        logic [31:0] right_item;
        logic [31:0] cursor_item;
        logic        empty;
        logic [6:0]  count;
    } dq_view_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [31:0]      s_tdata  = '0;
    logic [2:0]       s_tuser  = '0;
    logic             m_tready = 1'b0;
    logic             s_tready;
    logic             m_tvalid;
    logic [OUT_W-1:0] m_tdata;

    deque_with_cursor #(.DEPTH(DQC_DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [31:0] item_value
        .s_tuser  (s_tuser),    // [2:0] mode
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // status, popped, left, right, cursor, empty, count
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    dq_op_t   pending_ops[$];
    dq_view_t expected_views[$];
    dq_view_t oldest_view;
    int       total_ops;
    int       words_taken   = 0;
    int       words_offered = 0;
    int       mismatches    = 0;
    int       idle_cycles   = 0;

    // ------------------------------------------------------------------
    // Predictor: own copy of the ring buffer, left index, count and cursor
    // ------------------------------------------------------------------
    logic [31:0] ring[DQC_DEPTH];
    int          ring_head  = 0;
    int          ring_count = 0;
    int          cursor_pos = 0;

    function automatic int slot_of(input int offset);
        return (ring_head + offset) % DQC_DEPTH;
    endfunction

    function automatic dq_view_t apply_op(input mode_t op, input logic [31:0] value);
        dq_view_t v;
        v.status = ST_OK;
        v.popped = '0;
        case (op)
            MODE_PUSH_LEFT, MODE_PUSH_RIGHT: begin
                if (ring_count >= DQC_DEPTH) begin
                    v.status = ST_FULL;
                end else begin
                    if (op == MODE_PUSH_LEFT) begin
                        ring_head = (ring_head + DQC_DEPTH - 1) % DQC_DEPTH;
                        ring[ring_head] = value;
                        // cursor keeps its item, which is now one further from the left
                        if (ring_count != 0) cursor_pos++;
                    end else begin
                        ring[slot_of(ring_count)] = value;
                    end
                    // first item of an empty deque takes the cursor
                    if (ring_count == 0) cursor_pos = 0;
                    ring_count++;
                end
            end
            MODE_POP_LEFT: begin
                if (ring_count == 0) begin
                    v.status = ST_EMPTY;
                end else begin
                    v.popped = ring[ring_head];
                    ring_head = (ring_head + 1) % DQC_DEPTH;
                    ring_count--;
                    if (cursor_pos != 0) cursor_pos--;
                    if (ring_count == 0) cursor_pos = 0;
                end
            end
            MODE_POP_RIGHT: begin
                if (ring_count == 0) begin
                    v.status = ST_EMPTY;
                end else begin
                    v.popped = ring[slot_of(ring_count - 1)];
                    ring_count--;
                    // cursor on the removed item steps to its left neighbour
                    if (cursor_pos >= ring_count)
                        cursor_pos = (ring_count == 0) ? 0 : ring_count - 1;
                end
            end
            MODE_CURSOR_LEFT: begin
                if (ring_count == 0) v.status = ST_EMPTY;
                else if (cursor_pos == 0) v.status = ST_END;
                else cursor_pos--;
            end
            MODE_CURSOR_RIGHT: begin
                if (ring_count == 0) v.status = ST_EMPTY;
                else if (cursor_pos + 1 >= ring_count) v.status = ST_END;
                else cursor_pos++;
            end
            MODE_SET_CURSOR: begin
                if (ring_count == 0) v.status = ST_EMPTY;
                else ring[slot_of(cursor_pos)] = value;
            end
            default: begin
            end
        endcase
        if (ring_count == 0) begin
            v.left_item   = '0;
            v.right_item  = '0;
            v.cursor_item = '0;
            v.empty       = 1'b1;
        end else begin
            v.left_item   = ring[ring_head];
            v.right_item  = ring[slot_of(ring_count - 1)];
            v.cursor_item = ring[slot_of(cursor_pos)];
            v.empty       = 1'b0;
        end
        v.count = ring_count[6:0];
        return v;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on every input word taken, check every result word
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_views.push_back(apply_op(mode_t'(s_tuser), s_tdata));
                words_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_views.size() == 0) begin
                    $error("result word with nothing expected");
                    mismatches++;
                end else begin
                    oldest_view = expected_views.pop_front();
                    check_field("status", 32'(oldest_view.status),
                                32'(m_tdata[RES_STATUS_LSB +: 2]));
                    check_field("popped_value", oldest_view.popped,
                                m_tdata[RES_POP_LSB +: 32]);
                    check_field("left_item", oldest_view.left_item,
                                m_tdata[RES_LEFT_LSB +: 32]);
                    check_field("right_item", oldest_view.right_item,
                                m_tdata[RES_RIGHT_LSB +: 32]);
                    check_field("cursor_item", oldest_view.cursor_item,
                                m_tdata[RES_CURSOR_LSB +: 32]);
                    check_field("is_empty", 32'(oldest_view.empty),
                                32'(m_tdata[RES_EMPTY_BIT]));
                    check_field("item_count", 32'(oldest_view.count),
                                32'(m_tdata[RES_COUNT_LSB +: CNT_W]));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: bursts of words with random gaps; hold a word until taken
    // ------------------------------------------------------------------
    int     burst_left = 0;
    int     gap_left   = 0;
    dq_op_t next_op;

    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && words_taken < words_offered)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
                next_op = pending_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_op.op;
                s_tdata  <= next_op.value;
                words_offered++;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    // now and then a long burst with no gap at all
                    if ($urandom_range(0, 3) == 0) begin
                        burst_left = $urandom_range(50, 150);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = $urandom_range(1, 8);
                    end
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall patterns of its own, plus one long hold-off that
    // fills the output buffer and back-pressures the input side
    // ------------------------------------------------------------------
    int   hold_left    = 0;
    bit   hold_done    = 1'b0;
    int   pattern_kind = 0;
    int   pattern_left = 0;
    logic ready_next;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (!hold_done && words_taken >= HOLD_AT) begin
                hold_done  = 1'b1;
                hold_left  = HOLD_CYCLES - 1;
                ready_next = 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern_kind = $urandom_range(0, 2);
                    pattern_left = $urandom_range(10, 80);
                end
                pattern_left--;
                case (pattern_kind)
                    0: ready_next = 1'b1;
                    1: ready_next = ($urandom_range(0, 9) < 7);
                    default: ready_next = ($urandom_range(0, 9) < 3);
                endcase
            end
            m_tready <= ready_next;
        end
    end

    // Watchdog: end the run if no word moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[deque_with_cursor] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_op(input mode_t op, input logic [31:0] value);
        dq_op_t o;
        o.op    = op;
        o.value = value;
        pending_ops.push_back(o);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'h0;
            3: return 32'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    // bias 0 fills, 1 drains, 2 works the cursor, 3 mixes evenly
    function automatic mode_t pick_op(input int bias);
        int r;
        r = $urandom_range(0, 99);
        case (bias)
            0: begin
                if (r < 35) return MODE_PUSH_LEFT;
                if (r < 70) return MODE_PUSH_RIGHT;
                if (r < 78) return MODE_POP_LEFT;
                if (r < 85) return MODE_POP_RIGHT;
                if (r < 90) return MODE_CURSOR_LEFT;
                if (r < 95) return MODE_CURSOR_RIGHT;
                return MODE_SET_CURSOR;
            end
            1: begin
                if (r < 8)  return MODE_PUSH_LEFT;
                if (r < 15) return MODE_PUSH_RIGHT;
                if (r < 50) return MODE_POP_LEFT;
                if (r < 85) return MODE_POP_RIGHT;
                if (r < 90) return MODE_CURSOR_LEFT;
                if (r < 95) return MODE_CURSOR_RIGHT;
                return MODE_SET_CURSOR;
            end
            2: begin
                if (r < 10) return MODE_PUSH_LEFT;
                if (r < 20) return MODE_PUSH_RIGHT;
                if (r < 25) return MODE_POP_LEFT;
                if (r < 30) return MODE_POP_RIGHT;
                if (r < 55) return MODE_CURSOR_LEFT;
                if (r < 80) return MODE_CURSOR_RIGHT;
                return MODE_SET_CURSOR;
            end
            default: return mode_t'($urandom_range(0, 6));
        endcase
    endfunction

    initial begin
        int bias;
        int seg_len;
        int random_count;

        // every operation but a push is refused on an empty deque
        add_op(MODE_POP_LEFT,     32'h0);
        add_op(MODE_POP_RIGHT,    32'h0);
        add_op(MODE_CURSOR_LEFT,  32'h0);
        add_op(MODE_CURSOR_RIGHT, 32'h0);
        add_op(MODE_SET_CURSOR,   32'h1234_5678);
        // first push takes the cursor; push extremes at both ends
        add_op(MODE_PUSH_RIGHT,   32'h7fff_ffff);
        add_op(MODE_PUSH_LEFT,    32'h8000_0000);
        // cursor at the right end, then walk to the left end and past it
        add_op(MODE_CURSOR_RIGHT, 32'h0);
        add_op(MODE_CURSOR_LEFT,  32'h0);
        add_op(MODE_CURSOR_LEFT,  32'h0);
        add_op(MODE_SET_CURSOR,   32'hffff_ffff);
        add_op(MODE_PUSH_RIGHT,   32'h0);
        add_op(MODE_PUSH_LEFT,    32'h1);
        add_op(MODE_CURSOR_RIGHT, 32'h0);
        // pops at both ends, including the one under the cursor
        add_op(MODE_POP_LEFT,     32'h0);
        add_op(MODE_POP_RIGHT,    32'h0);
        add_op(MODE_CURSOR_RIGHT, 32'h0);
        add_op(MODE_POP_RIGHT,    32'h0);
        add_op(MODE_POP_LEFT,     32'h0);
        // pop of the last item clears the cursor
        add_op(MODE_POP_LEFT,     32'h0);
        add_op(MODE_POP_RIGHT,    32'h0);
        add_op(MODE_PUSH_LEFT,    32'h5555_5555);
        add_op(MODE_SET_CURSOR,   32'haaaa_aaaa);
        add_op(MODE_POP_RIGHT,    32'h0);
        add_op(MODE_PUSH_RIGHT,   32'hdead_beef);

        // segments of biased operations reach full, empty and both cursor ends
        bias = 0;
        random_count = 0;
        while (random_count < RANDOM_OPS) begin
            seg_len = $urandom_range(80, 160);
            if (seg_len > RANDOM_OPS - random_count) seg_len = RANDOM_OPS - random_count;
            repeat (seg_len) add_op(pick_op(bias), pick_value());
            random_count += seg_len;
            bias = (bias + 1) % 4;
        end
        total_ops = pending_ops.size();

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (words_taken < total_ops) @(negedge aclk);
        while (expected_views.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatches == 0) begin
            $display("[deque_with_cursor] OK");
        end else begin
            $display("[deque_with_cursor] ERROR");
        end
        $finish;
    end

endmodule
